FILE: hw/rtl/lba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_pkg: shared types and constants of the block allocator
// Request and result codes, sequencer states and the bitmap control structs.
// ----------------------------------------------------------------------------
package lba_pkg;

  localparam int LBA_DISK_BLOCKS = 64;
  localparam int LBA_IDX_W       = 6;   // width of block_index and free_block
  localparam int LBA_CNT_W       = 7;   // width of request_count and free_total

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_ALLOC = 2'd0,
    STATUS_FAIL  = 2'd1,
    STATUS_FREED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Controller to bitmap: one addressed bit is read, and may be set or cleared.
  typedef struct packed {
    logic                 set_bit;
    logic                 clr_bit;
    logic [LBA_IDX_W-1:0] idx;
  } bm_req_t;

  // Bitmap to controller.
  typedef struct packed {
    logic                 bit_occupied;
    logic [LBA_CNT_W-1:0] free_total;
  } bm_stat_t;

endpackage

FILE: hw/rtl/lba_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_bitmap: occupied bitmap and free block count
// One bit per disk block, read at one address a cycle, with set and clear.
// ----------------------------------------------------------------------------
module lba_bitmap
  import lba_pkg::*;
#(
  parameter int DISK_BLOCKS = LBA_DISK_BLOCKS
) (
  input  logic     clk,
  input  logic     rst,
  input  bm_req_t  bm_req,
  output bm_stat_t bm_stat
);

  localparam int IdxW = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;

  logic [DISK_BLOCKS-1:0] occupied_map;
  logic [LBA_CNT_W-1:0]   free_total;
  logic                   in_range;
  logic [IdxW-1:0]        bit_idx;

  assign bit_idx  = bm_req.idx[IdxW-1:0];
  // Indexes past the last block read as free and are never written.
  assign in_range = ({1'b0, bm_req.idx} < LBA_CNT_W'(DISK_BLOCKS));

  assign bm_stat.bit_occupied = in_range && occupied_map[bit_idx];
  assign bm_stat.free_total   = free_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_map <= '0;
      free_total   <= LBA_CNT_W'(DISK_BLOCKS);
    end else if (bm_req.set_bit && in_range) begin
      occupied_map[bit_idx] <= 1'b1;
      free_total            <= free_total - 1'b1;
    end else if (bm_req.clr_bit && in_range) begin
      occupied_map[bit_idx] <= 1'b0;
      free_total            <= free_total + 1'b1;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= LBA_CNT_W'(DISK_BLOCKS))
    else $error("free block count exceeds the number of blocks");

  a_set_free_only: assert property (@(posedge clk) disable iff (rst)
    bm_req.set_bit |-> (!bm_stat.bit_occupied && !bm_req.clr_bit))
    else $error("allocation of a block that is already occupied");

  a_clr_used_only: assert property (@(posedge clk) disable iff (rst)
    bm_req.clr_bit |-> bm_stat.bit_occupied)
    else $error("release of a block that is not occupied");

  a_set_counts: assert property (@(posedge clk) disable iff (rst)
    bm_req.set_bit |=> (free_total == $past(free_total) - 1'b1))
    else $error("free block count did not drop on allocation");

endmodule

FILE: hw/rtl/lba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_ctrl: request sequencer and result register
// Decodes a request, walks the scan pointer over the bitmap one block a cycle
// but for stalls on an undrained output register, and loads each result into it.
// ----------------------------------------------------------------------------
module lba_ctrl
  import lba_pkg::*;
#(
  parameter int DISK_BLOCKS = LBA_DISK_BLOCKS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [LBA_CNT_W-1:0] request_count,
  input  logic [LBA_IDX_W-1:0] free_block,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LBA_IDX_W-1:0] block_index,
  output logic [1:0]           status,
  output logic                 last,
  output bm_req_t              bm_req,
  input  bm_stat_t             bm_stat
);

  localparam int IdxW = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;

  state_t               state, state_next;
  cmd_t                 cmd_q, cmd_q_next;
  logic [LBA_CNT_W-1:0] count_q, count_q_next;
  logic [LBA_IDX_W-1:0] blk_q, blk_q_next;
  logic [IdxW-1:0]      ptr, ptr_next;
  logic [LBA_CNT_W-1:0] remaining, remaining_next;

  logic                 slot_ok;
  logic                 load;
  logic [LBA_IDX_W-1:0] load_index;
  status_t              load_status;
  logic                 load_last;

  // The result register can take a new result when empty or being drained.
  assign slot_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q     <= cmd_q_next;
    count_q   <= count_q_next;
    blk_q     <= blk_q_next;
    ptr       <= ptr_next;
    remaining <= remaining_next;
  end

  always_comb begin
    state_next     = state;
    cmd_q_next     = cmd_q;
    count_q_next   = count_q;
    blk_q_next     = blk_q;
    ptr_next       = ptr;
    remaining_next = remaining;
    in_ready       = 1'b0;
    bm_req         = '0;
    load           = 1'b0;
    load_index     = '0;
    load_status    = STATUS_FREED;
    load_last      = 1'b1;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_q_next   = cmd_t'(command);
          count_q_next = request_count;
          blk_q_next   = free_block;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_q == CMD_FREE) begin
          bm_req.idx = blk_q;
          if (slot_ok) begin
            bm_req.clr_bit = bm_stat.bit_occupied;
            load           = 1'b1;
            load_status    = STATUS_FREED;
            state_next     = ST_IDLE;
          end
        end else if (count_q == '0 || count_q > bm_stat.free_total) begin
          if (slot_ok) begin
            load        = 1'b1;
            load_status = STATUS_FAIL;
            state_next  = ST_IDLE;
          end
        end else begin
          remaining_next = count_q;
          ptr_next       = '0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        bm_req.idx = LBA_IDX_W'(ptr);
        if (bm_stat.bit_occupied) begin
          ptr_next = ptr + 1'b1;
        end else if (slot_ok) begin
          bm_req.set_bit = 1'b1;
          load           = 1'b1;
          load_index     = LBA_IDX_W'(ptr);
          load_status    = STATUS_ALLOC;
          load_last      = (remaining == LBA_CNT_W'(1));
          remaining_next = remaining - 1'b1;
          ptr_next       = ptr + 1'b1;
          if (remaining == LBA_CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      block_index <= load_index;
      status      <= load_status;
      last        <= load_last;
    end
  end

  a_scan_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (remaining != '0))
    else $error("scan running with no blocks left to allocate");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> slot_ok)
    else $error("result loaded over one that was not taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(block_index) &&
                                   $stable(status) && $stable(last)))
    else $error("result changed while waiting to be taken");

endmodule

FILE: hw/rtl/linked_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_block_allocator: first-fit bitmap block allocator
// Usage:
//   Requests arrive on in_valid/in_ready with command, request_count and
//   free_block. An allocate request (command 0) returns one result per block,
//   in ascending block order, each with status 0 and last set on the final
//   one. If the count is zero or more than the free blocks, one result with
//   status 1 is returned and nothing is allocated. A free request (command 1)
//   frees the block if it is taken; it always returns one result, status 2.
//   Results leave on out_valid/out_ready through a single output register.
// Timing:
//   A request is taken in ST_IDLE and decoded in the next state, ST_EXEC;
//   free and failed requests then have their result registered before a
//   new request is taken. An allocation walks the bitmap one block per
//   cycle from block 0, but stalls on a found block while the output
//   register is not drained. in_ready is high only between requests.
// Reset marks every block free. A stalled receiver holds the sequencer
// at its next result until the output register is drained; none is dropped.
// ----------------------------------------------------------------------------
module linked_block_allocator
  import lba_pkg::*;
#(
  parameter int DISK_BLOCKS = LBA_DISK_BLOCKS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [LBA_CNT_W-1:0] request_count,
  input  logic [LBA_IDX_W-1:0] free_block,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LBA_IDX_W-1:0] block_index,
  output logic [1:0]           status,
  output logic                 last
);

  bm_req_t  bm_req;
  bm_stat_t bm_stat;

  lba_ctrl #(
    .DISK_BLOCKS(DISK_BLOCKS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .request_count(request_count),
    .free_block   (free_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .block_index  (block_index),
    .status       (status),
    .last         (last),
    .bm_req       (bm_req),
    .bm_stat      (bm_stat)
  );

  lba_bitmap #(
    .DISK_BLOCKS(DISK_BLOCKS)
  ) u_bitmap (
    .clk    (clk),
    .rst    (rst),
    .bm_req (bm_req),
    .bm_stat(bm_stat)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for linked_block_allocator
// Drives allocate and free requests with bursty timing against a stalling
// receiver, tracks the occupied map on the side and checks every result in
// order against the expected block index, status and last flag.
// ----------------------------------------------------------------------------
module tb;
  import lba_pkg::*;

  localparam int QUIET_LIMIT  = 5000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 100;   // longer than a full 64-block scan

  typedef struct packed {
    logic [LBA_IDX_W-1:0] blk_idx;
    status_t              st;
    logic                 last;
  } block_result_t;

  // Tracks which blocks are taken and the results still owed by the block.
  class block_map_model;
    bit            occupied [LBA_DISK_BLOCKS];
    int            free_total;
    block_result_t due_results[$];
    int            errors;

    function new();
      foreach (occupied[b]) occupied[b] = 1'b0;
      free_total = LBA_DISK_BLOCKS;
      errors     = 0;
    endfunction

    function void owe(int idx, status_t st, logic last);
      block_result_t r;
      r.blk_idx = LBA_IDX_W'(idx);
      r.st      = st;
      r.last    = last;
      due_results.push_back(r);
    endfunction

    function void note_request(cmd_t cmd, logic [LBA_CNT_W-1:0] count,
                               logic [LBA_IDX_W-1:0] blk);
      int granted;
      granted = 0;
      if (cmd == CMD_FREE) begin
        if (int'(blk) < LBA_DISK_BLOCKS && occupied[blk]) begin
          occupied[blk] = 1'b0;
          free_total++;
        end
        owe(0, STATUS_FREED, 1'b1);
      end else if (count == 0 || int'(count) > free_total) begin
        owe(0, STATUS_FAIL, 1'b1);
      end else begin
        // First fit: lowest free blocks, in ascending order.
        for (int b = 0; b < LBA_DISK_BLOCKS && granted < int'(count); b++) begin
          if (!occupied[b]) begin
            occupied[b] = 1'b1;
            free_total--;
            granted++;
            owe(b, STATUS_ALLOC, granted == int'(count));
          end
        end
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [LBA_IDX_W-1:0] idx, logic [1:0] st, logic last);
      block_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result: index %0d status %0d last %0d",
                         idx, st, last));
        return;
      end
      want = due_results.pop_front();
      if (idx !== want.blk_idx)
        report($sformatf("block_index %0d, expected %0d", idx, want.blk_idx));
      if (st !== want.st)
        report($sformatf("status %0d, expected %0d", st, want.st));
      if (last !== want.last)
        report($sformatf("last %0d, expected %0d", last, want.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = 1'b0;
  logic [LBA_CNT_W-1:0] request_count = '0;
  logic [LBA_IDX_W-1:0] free_block = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LBA_IDX_W-1:0] block_index;
  logic [1:0]           status;
  logic                 last;

  block_map_model map = new();
  int             burst_left = 0;
  int             quiet_cycles = 0;
  logic [9:0]     rx_cycle = '0;

  linked_block_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .request_count (request_count),
    .free_block    (free_block),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .block_index   (block_index),
    .status        (status),
    .last          (last)
  );

  always #1 clk = ~clk;

  // Holds the request until it is taken, then either keeps valid up for the
  // next request of the burst or drops it for a random gap.
  task automatic send_request(cmd_t cmd, logic [LBA_CNT_W-1:0] cnt,
                              logic [LBA_IDX_W-1:0] blk);
    in_valid      <= 1'b1;
    command       <= cmd;
    request_count <= cnt;
    free_block    <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    map.note_request(cmd, cnt, blk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Receiver cycles through steady, light, long-stall and coin-flip phases.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= rx_cycle[4];
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) map.check_result(block_index, status, last);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("linked_block_allocator test failed");
    $finish;
  end

  initial begin
    int roll;
    int alloc_pct;
    int held[$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(CMD_FREE, 7'd0, 6'd0);        // block already free
    send_request(CMD_ALLOC, 7'd0, 6'd0);       // zero count
    send_request(CMD_ALLOC, 7'd127, 6'd63);    // count far above the disk size
    send_request(CMD_ALLOC, 7'd65, 6'd0);
    send_request(CMD_ALLOC, 7'd1, 6'd0);
    send_request(CMD_ALLOC, 7'd64, 6'd0);      // one short of enough
    send_request(CMD_FREE, 7'd127, 6'd0);
    send_request(CMD_ALLOC, 7'd64, 6'd0);      // whole disk
    send_request(CMD_ALLOC, 7'd1, 6'd0);       // disk full
    send_request(CMD_FREE, 7'd0, 6'd63);
    send_request(CMD_FREE, 7'd0, 6'd42);
    send_request(CMD_FREE, 7'd0, 6'd21);
    send_request(CMD_FREE, 7'd0, 6'd5);
    send_request(CMD_ALLOC, 7'd3, 6'd0);       // scattered holes
    send_request(CMD_FREE, 7'd0, 6'd21);
    send_request(CMD_FREE, 7'd0, 6'd21);       // second release of the same block
    send_request(CMD_ALLOC, 7'd2, 6'd0);
    send_request(CMD_ALLOC, 7'd1, 6'd0);       // disk full again

    for (int n = 0; n < 112; n++) begin
      roll      = $urandom_range(0, 99);
      alloc_pct = (map.free_total > 16) ? 60 : 30;
      if (roll < 5) begin
        send_request(CMD_ALLOC, LBA_CNT_W'($urandom_range(0, 127)), LBA_IDX_W'($urandom));
      end else if (roll < 10) begin
        // Exactly what is left, or one more than that.
        send_request(CMD_ALLOC, LBA_CNT_W'(map.free_total + $urandom_range(0, 1)),
                     LBA_IDX_W'($urandom));
      end else if (roll < alloc_pct) begin
        send_request(CMD_ALLOC, LBA_CNT_W'($urandom_range(1, 8)), LBA_IDX_W'($urandom));
      end else begin
        held.delete();
        foreach (map.occupied[b]) if (map.occupied[b]) held.push_back(b);
        if (held.size() != 0 && $urandom_range(0, 4) != 0)
          send_request(CMD_FREE, LBA_CNT_W'($urandom),
                       LBA_IDX_W'(held[$urandom_range(0, held.size() - 1)]));
        else
          send_request(CMD_FREE, LBA_CNT_W'($urandom), LBA_IDX_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (map.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (map.errors == 0) begin
      $display("linked_block_allocator test passed");
    end else begin
      $display("linked_block_allocator test failed");
    end
    $finish;
  end

endmodule
